[hdl/tdr_pkg.sv]
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types and codes of the transmit ring DMA chunk scheduler.
// ----------------------------------------------------------------------------
package tdr_pkg;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 9;
    localparam int ADDR_W   = 9;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DONE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ISSUE,
        ST_MOD,
        ST_MEMRD,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic issue;
        logic modr;
        logic mem_rd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic need_issue;
        logic is_read;
        logic out_free;
    } sts_t;

endpackage

[hdl/tdr_ctrl.sv]
// ----------------------------------------------------------------------------
// tdr_ctrl
// Sequencer: steps one request through execute, chunk issue, ring read and
// response hand-off.
// ----------------------------------------------------------------------------
module tdr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tdr_pkg::sts_t sts,
    output tdr_pkg::cmd_t cmd
);
    import tdr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.is_read) begin
                    state_next = ST_MOD;
                end else if (sts.need_issue) begin
                    state_next = ST_ISSUE;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_ISSUE: state_next = ST_RESP;
            ST_MOD:   state_next = ST_MEMRD;
            ST_MEMRD: state_next = ST_RESP;
            ST_RESP: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            ST_EXEC:  cmd.exec   = 1'b1;
            ST_ISSUE: cmd.issue  = 1'b1;
            ST_MOD:   cmd.modr   = 1'b1;
            ST_MEMRD: cmd.mem_rd = 1'b1;
            ST_RESP:  cmd.load_out = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

[hdl/tdr_datapath.sv]
// ----------------------------------------------------------------------------
// tdr_datapath
// Ring memory, pointers and counters, chunk computation, read address
// wrap and the output register.
// ----------------------------------------------------------------------------
module tdr_datapath #(
    parameter int RING_DEPTH = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [tdr_pkg::FUNC_W-1:0]       s_tuser,
    input  logic [tdr_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tdr_pkg::M_DATA_W-1:0]     m_tdata,
    output logic [tdr_pkg::STATUS_W-1:0]     m_tuser,
    input  tdr_pkg::cmd_t                    cmd,
    output tdr_pkg::sts_t                    sts
);
    import tdr_pkg::*;

    localparam int PTR_W   = $clog2(RING_DEPTH);
    localparam int W       = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
    localparam int MOD_SH  = 18;
    localparam int MOD_MUL = (1 << MOD_SH) / RING_DEPTH;
    localparam int QP_W    = ADDR_W + MOD_SH;
    localparam int QD_W    = ADDR_W + 18;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];

    logic [FUNC_W-1:0] func_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] pend_reg, pend_next;
    logic [PTR_W-1:0] infl_reg, infl_next;
    logic             busy_reg, busy_next;
    logic [LEN_W-1:0] brem_reg, brem_next;

    logic [STATUS_W-1:0] rstat_reg, rstat_next;
    logic                rstart_reg, rstart_next;
    logic [ADDR_W-1:0]   raddr_reg, raddr_next;
    logic [LEN_W-1:0]    rlen_reg, rlen_next;
    logic [BYTE_W-1:0]   rdata_reg;

    logic [ADDR_W-1:0] q_reg;
    logic [PTR_W-1:0]  ridx_reg;

    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [STATUS_W-1:0] out_user_reg;

    logic [W-1:0]      room_w;
    logic              do_write;
    logic              mem_we;
    logic [LEN_W-1:0]  brem_eff;
    logic              exec_issue;
    logic [W-1:0]      croom_w;
    logic [W-1:0]      pend_w;
    logic [W-1:0]      chunk_w;
    logic [W-1:0]      rp_sum;
    logic [QP_W-1:0]   q_prod;
    logic [QD_W-1:0]   qd_prod;
    logic [QD_W-1:0]   r_full;
    logic [QD_W-1:0]   r_corr;

    // write request: fit check, ring write, issue decision
    always_comb begin
        room_w     = W'(RING_DEPTH - 1) - W'(pend_reg);
        do_write   = 1'b0;
        exec_issue = 1'b0;
        brem_eff   = brem_reg;
        if (brem_reg == '0) begin
            if (W'(len_reg) > room_w) begin
                do_write = 1'b0;
            end else if (len_reg == '0) begin
                exec_issue = 1'b1;
            end else begin
                do_write = 1'b1;
                brem_eff = len_reg;
            end
        end else begin
            do_write = 1'b1;
        end
        if (do_write && brem_eff == LEN_W'(1)) begin
            exec_issue = 1'b1;
        end
    end

    assign mem_we = cmd.exec && func_reg == FUNC_WRITE && do_write;

    always_comb begin
        croom_w = W'(RING_DEPTH) - W'(rp_reg);
        pend_w  = W'(pend_reg);
        chunk_w = (pend_w > croom_w) ? croom_w : pend_w;
        rp_sum  = W'(rp_reg) + chunk_w;
    end

    assign q_prod  = QP_W'(addr_reg) * QP_W'(MOD_MUL);
    assign qd_prod = QD_W'(q_reg) * QD_W'(RING_DEPTH);
    assign r_full  = QD_W'(addr_reg) - qd_prod;
    assign r_corr  = (r_full >= QD_W'(RING_DEPTH)) ? r_full - QD_W'(RING_DEPTH) : r_full;

    always_comb begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        pend_next   = pend_reg;
        infl_next   = infl_reg;
        busy_next   = busy_reg;
        brem_next   = brem_reg;
        rstat_next  = rstat_reg;
        rstart_next = rstart_reg;
        raddr_next  = raddr_reg;
        rlen_next   = rlen_reg;
        if (cmd.latch) begin
            rstat_next  = ST_OK;
            rstart_next = 1'b0;
            raddr_next  = '0;
            rlen_next   = '0;
        end
        if (cmd.exec) begin
            case (func_reg)
                FUNC_WRITE: begin
                    if (brem_reg == '0 && W'(len_reg) > room_w) begin
                        rstat_next = ST_REJECT;
                    end
                    if (do_write) begin
                        wp_next   = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0
                                                                       : wp_reg + PTR_W'(1);
                        pend_next = pend_reg + PTR_W'(1);
                        brem_next = brem_eff - LEN_W'(1);
                    end
                end
                FUNC_DONE: begin
                    if (!busy_reg) begin
                        rstat_next = ST_IGNORED;
                    end else begin
                        pend_next = pend_reg - infl_reg;
                        infl_next = '0;
                        busy_next = 1'b0;
                    end
                end
                default: begin
                    rstat_next = ST_OK;
                end
            endcase
        end
        if (cmd.issue && !busy_reg && pend_reg != '0) begin
            rstart_next = 1'b1;
            raddr_next  = ADDR_W'(rp_reg);
            rlen_next   = LEN_W'(chunk_w);
            busy_next   = 1'b1;
            infl_next   = PTR_W'(chunk_w);
            rp_next     = (rp_sum >= W'(RING_DEPTH)) ? PTR_W'(rp_sum - W'(RING_DEPTH))
                                                     : PTR_W'(rp_sum);
        end
    end

    always_comb begin
        sts.is_read    = (func_reg == FUNC_READ);
        sts.need_issue = (func_reg == FUNC_WRITE) ? exec_issue
                       : (func_reg == FUNC_DONE)  ? busy_reg : 1'b0;
        sts.out_free   = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            pend_reg <= '0;
            infl_reg <= '0;
            busy_reg <= 1'b0;
            brem_reg <= '0;
        end else begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            pend_reg <= pend_next;
            infl_reg <= infl_next;
            busy_reg <= busy_next;
            brem_reg <= brem_next;
        end
    end

    always_ff @(posedge aclk) begin
        rstat_reg  <= rstat_next;
        rstart_reg <= rstart_next;
        raddr_reg  <= raddr_next;
        rlen_reg   <= rlen_next;
        if (cmd.latch) begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata[BYTE_W-1:0];
            len_reg  <= s_tdata[BYTE_W +: LEN_W];
            addr_reg <= s_tdata[BYTE_W+LEN_W +: ADDR_W];
            rdata_reg <= '0;
        end
        if (cmd.exec) begin
            q_reg <= q_prod[QP_W-1 -: ADDR_W];
        end
        if (cmd.modr) begin
            ridx_reg <= PTR_W'(r_corr);
        end
        if (cmd.mem_rd) begin
            rdata_reg <= ring_mem[ridx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wp_reg] <= byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_user_reg <= rstat_reg;
            out_data_reg <= M_DATA_W'({rdata_reg, rlen_reg, raddr_reg, rstart_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[hdl/tx_ring_dma_chunk_scheduler.sv]
// ----------------------------------------------------------------------------
// tx_ring_dma_chunk_scheduler
// Transmit byte ring that schedules contiguous DMA chunks.
// ----------------------------------------------------------------------------
// One request at a time is handled by a small sequencer. A write, done or
// unused request passes through an execute state, a chunk issue state when a
// chunk may start, and a response state that loads the output register; a
// ring read passes through execute, a modulo state and a memory read state,
// set by the two-step address wrap and the registered read port of the ring
// memory. A new request is taken only once the previous one has loaded the
// output register; while the output register still holds an unread response,
// the response state repeats until it drains. The next request is accepted
// while the previous response still waits in the output register. The ring
// needs no clearing after reset. Every request gives exactly one response.
// ----------------------------------------------------------------------------
module tx_ring_dma_chunk_scheduler #(
    parameter int RING_DEPTH = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [7:0] data_byte, [16:8] msg_len, [25:17] read_addr, rest zero
    input  logic [tdr_pkg::S_DATA_W-1:0]     s_tdata,
    // [1:0] func
    input  logic [tdr_pkg::FUNC_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] dma_start, [9:1] dma_addr, [18:10] dma_len, [26:19] read_data
    output logic [tdr_pkg::M_DATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [tdr_pkg::STATUS_W-1:0]     m_tuser
);
    import tdr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdr_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .sts      (sts)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    a_start_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tuser == ST_OK && m_tdata[18:10] != 9'd0)
        else $error("chunk issued with bad status or zero length");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_REJECT || m_tuser == ST_IGNORED)
        |-> m_tdata[26:0] == 27'd0)
        else $error("rejected or ignored request carries data");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !m_tvalid || m_tready)
        else $error("response overwrites a pending one");
`endif

endmodule
